// ----- hw/rtl/bitmap_slot_allocator_assert.svh -----
// Assertion macros used by the slot allocator top level.
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication under the block's reset.
`define BSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsa: same-cycle check failed");

// Next-cycle implication under the block's reset.
`define BSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsa: next-cycle check failed");

`endif

// ----- hw/rtl/bsa_pkg.sv -----
// Types, constants and microcode program of the bitmap slot allocator.
package bsa_pkg;

    localparam int unsigned DEF_MAX_WORDS = 64;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned BIT_W         = 5;
    localparam int unsigned HANDLE_W      = 12;
    localparam int unsigned WIU_W         = 7;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned STEP_W        = 3;

    localparam logic [WIU_W-1:0] WIU_RESET = 7'd64;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [HANDLE_W-1:0] slot_handle;
    } cmd_word_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] result_handle;
        logic [STATUS_W-1:0] status;
    } result_word_t;

    typedef logic [STEP_W-1:0] step_t;

    // Program addresses; the two command entries sit side by side so
    // the idle step can dispatch on the operation bit.
    localparam step_t S_CLR    = 3'd0;
    localparam step_t S_IDLE   = 3'd1;
    localparam step_t S_A_CHK  = 3'd2;
    localparam step_t S_F_CHK  = 3'd3;
    localparam step_t S_A_TEST = 3'd4;
    localparam step_t S_A_SET  = 3'd5;
    localparam step_t S_F_CLR  = 3'd6;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_START,
        COND_CLR_DONE,
        COND_SCAN_END,
        COND_WORD_OPEN,
        COND_RANGE
    } cond_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC,
        PTR_INC_NT
    } ptr_op_t;

    typedef enum logic {
        ADDR_PTR,
        ADDR_HANDLE
    } addr_sel_t;

    typedef enum logic [1:0] {
        WSEL_ZERO,
        WSEL_SET,
        WSEL_CLEAR
    } wsel_t;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_ALLOC,
        OUT_FULL,
        OUT_RANGE,
        OUT_FREE
    } out_t;

    typedef struct packed {
        cond_t     cond;
        logic      dispatch;
        step_t     tgt_t;
        step_t     tgt_f;
        ptr_op_t   ptr_op;
        addr_sel_t addr_sel;
        logic      mem_rd;
        logic      mem_wr;
        wsel_t     wsel;
        out_t      out;
        logic      idle;
        logic      load_cmd;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   taken;
    } seq_ctrl_t;

    typedef struct packed {
        logic clr_done;
        logic scan_end;
        logic word_open;
        logic range_err;
    } seq_flags_t;

    // Control store: one word per step. A result is issued when the
    // step's branch is taken and its out field is not OUT_NONE.
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t u;
        u.cond     = COND_ALWAYS;
        u.dispatch = 1'b0;
        u.tgt_t    = S_IDLE;
        u.tgt_f    = S_IDLE;
        u.ptr_op   = PTR_HOLD;
        u.addr_sel = ADDR_PTR;
        u.mem_rd   = 1'b0;
        u.mem_wr   = 1'b0;
        u.wsel     = WSEL_ZERO;
        u.out      = OUT_NONE;
        u.idle     = 1'b0;
        u.load_cmd = 1'b0;
        case (s)
            S_CLR:
            begin
                u.cond   = COND_CLR_DONE;
                u.tgt_f  = S_CLR;
                u.ptr_op = PTR_INC;
                u.mem_wr = 1'b1;
                u.wsel   = WSEL_ZERO;
            end
            S_IDLE:
            begin
                u.cond     = COND_START;
                u.dispatch = 1'b1;
                u.tgt_t    = S_A_CHK;
                u.tgt_f    = S_IDLE;
                u.ptr_op   = PTR_ZERO;
                u.idle     = 1'b1;
                u.load_cmd = 1'b1;
            end
            S_A_CHK:
            begin
                u.cond   = COND_SCAN_END;
                u.tgt_f  = S_A_TEST;
                u.mem_rd = 1'b1;
                u.out    = OUT_FULL;
            end
            S_F_CHK:
            begin
                u.cond     = COND_RANGE;
                u.tgt_f    = S_F_CLR;
                u.addr_sel = ADDR_HANDLE;
                u.mem_rd   = 1'b1;
                u.out      = OUT_RANGE;
            end
            S_A_TEST:
            begin
                u.cond   = COND_WORD_OPEN;
                u.tgt_t  = S_A_SET;
                u.tgt_f  = S_A_CHK;
                u.ptr_op = PTR_INC_NT;
            end
            S_A_SET:
            begin
                u.mem_wr = 1'b1;
                u.wsel   = WSEL_SET;
                u.out    = OUT_ALLOC;
            end
            S_F_CLR:
            begin
                u.addr_sel = ADDR_HANDLE;
                u.mem_wr   = 1'b1;
                u.wsel     = WSEL_CLEAR;
                u.out      = OUT_FREE;
            end
            default:
            begin
                u.tgt_t = S_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

// ----- hw/rtl/bitmap_slot_allocator.sv -----
// Top level of the bitmap first-fit slot allocator.
//
// First-fit slot allocator over MAX_WORDS bitmap words of 32 slots each.
// Issue a command word with start while busy is low. Allocate scans the
// first words_in_use words from word 0 and claims the lowest clear bit of
// the first word that is not full, returning the 1-based handle; free
// clears the bit of a 1-based handle. Each command gives exactly one
// result word on result, shown for one cycle with done high; the receiver
// cannot stall it, so capture it on that cycle. After reset the block
// sweeps the bitmap to zero, one word a cycle, and holds busy high until the
// sweep ends. Timing is set by the microcode loop over the single-port
// bitmap memory, which reads and tests one word per pass: an allocate makes
// a pass per word up to the word it lands in, a full scan a pass per
// searched word and a last check; a free checks the handle, then clears its
// bit, and an out-of-range free ends at the check. busy drops the cycle done
// rises. Write words_in_use only while busy is low and no result is due.
module bitmap_slot_allocator
    import bsa_pkg::*;
#(
    parameter int unsigned MAX_WORDS = DEF_MAX_WORDS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_word_t        cmd,
    output logic             done,
    output result_word_t     result,
    input  logic             cfg_wr_en,
    input  logic [WIU_W-1:0] cfg_wr_data
);

`include "bitmap_slot_allocator_assert.svh"

    logic [WIU_W-1:0] words_in_use_reg;
    logic [WIU_W-1:0] words_in_use_next;
    seq_ctrl_t        ctrl;
    seq_flags_t       flags;

    // Hold the scan length; take a new value on each write.
    assign words_in_use_next = cfg_wr_en ? cfg_wr_data : words_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_in_use_reg <= WIU_RESET;
        end
        else
        begin
            words_in_use_reg <= words_in_use_next;
        end
    end

    // Advance the program one step a cycle; branch on datapath flags.
    bsa_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (cmd.operation),
        .flags     (flags),
        .ctrl      (ctrl),
        .busy      (busy)
    );

    // Pointer, bitmap memory and result register driven by the control word.
    bsa_datapath #(
        .MAX_WORDS (MAX_WORDS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .words_in_use (words_in_use_reg),
        .ctrl         (ctrl),
        .flags        (flags),
        .done         (done),
        .result       (result)
    );

    // An accepted command always occupies the block on the next cycle.
    `BSA_ASSERT_NXT(a_accept_then_busy, clk, rst_n, start && !busy, busy)
    // A result only follows a cycle of work.
    `BSA_ASSERT_IMP(a_done_after_busy, clk, rst_n, done, $past(busy))
    // Never repeat a result word.
    `BSA_ASSERT_NXT(a_done_single, clk, rst_n, done, !done)
    // A failed command returns no handle.
    `BSA_ASSERT_IMP(a_fail_no_handle, clk, rst_n, done && result.status != ST_OK, result.result_handle == '0)

endmodule

// ----- hw/rtl/bsa_seq.sv -----
// Microcode sequencer: step counter, control store and branch logic.
module bsa_seq
    import bsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       operation,
    input  seq_flags_t flags,
    output seq_ctrl_t  ctrl,
    output logic       busy
);

    step_t  step_reg;
    step_t  step_next;
    ucode_t uc;
    logic   taken;

    assign uc = ucode_rom(step_reg);

    always_comb
    begin
        case (uc.cond)
            COND_ALWAYS:    taken = 1'b1;
            COND_START:     taken = start;
            COND_CLR_DONE:  taken = flags.clr_done;
            COND_SCAN_END:  taken = flags.scan_end;
            COND_WORD_OPEN: taken = flags.word_open;
            COND_RANGE:     taken = flags.range_err;
            default:        taken = 1'b1;
        endcase
    end

    // Dispatch folds the operation bit into the target address.
    always_comb
    begin
        if (taken)
        begin
            if (uc.dispatch)
            begin
                step_next = uc.tgt_t | STEP_W'(operation);
            end
            else
            begin
                step_next = uc.tgt_t;
            end
        end
        else
        begin
            step_next = uc.tgt_f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_CLR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign ctrl.uc    = uc;
    assign ctrl.taken = taken;
    assign busy       = ~uc.idle;

endmodule

// ----- hw/rtl/bsa_datapath.sv -----
// Datapath: word pointer, bitmap memory, bit search and result register.
module bsa_datapath
    import bsa_pkg::*;
#(
    parameter int unsigned MAX_WORDS = DEF_MAX_WORDS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cmd_word_t          cmd,
    input  logic [WIU_W-1:0]   words_in_use,
    input  seq_ctrl_t          ctrl,
    output seq_flags_t         flags,
    output logic               done,
    output result_word_t       result
);

    localparam int unsigned WIDX   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int unsigned PW     = WIDX + 1;
    localparam int unsigned CW     = (WIU_W > PW) ? WIU_W : PW;
    localparam int unsigned HW     = (WIDX + 6 > HANDLE_W) ? WIDX + 6 : HANDLE_W;
    localparam int unsigned NSLOTS = MAX_WORDS * WORD_W;

    logic [WORD_W-1:0]   bitmap_mem [MAX_WORDS];
    logic [WORD_W-1:0]   rdata_reg;
    logic [PW-1:0]       ptr_reg;
    logic [PW-1:0]       ptr_next;
    logic [HANDLE_W-1:0] handle_reg;
    logic                done_reg;
    result_word_t        result_reg;
    result_word_t        result_next;

    logic [CW-1:0]       limit;
    logic [HW-1:0]       hm1;
    logic [WIDX-1:0]     hword;
    logic [BIT_W-1:0]    hbit;
    logic [WIDX-1:0]     addr;
    logic [WORD_W-1:0]   wdata;
    logic [BIT_W-1:0]    free_idx;
    logic [HW-1:0]       alloc_handle;
    logic                emit;

    // Clamp the scan length to the store depth.
    assign limit = (CW'(words_in_use) > CW'(MAX_WORDS)) ? CW'(MAX_WORDS)
                                                         : CW'(words_in_use);

    assign hm1   = HW'(handle_reg) - HW'(1);
    assign hword = hm1[WIDX+BIT_W-1:BIT_W];
    assign hbit  = hm1[BIT_W-1:0];

    assign flags.clr_done  = (ptr_reg == PW'(MAX_WORDS - 1));
    assign flags.scan_end  = (CW'(ptr_reg) == limit);
    assign flags.word_open = ~(&rdata_reg);
    assign flags.range_err = (handle_reg == '0) || (HW'(handle_reg) > HW'(NSLOTS));

    // Lowest clear bit of the word just read.
    always_comb
    begin
        free_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!rdata_reg[i])
            begin
                free_idx = BIT_W'(i);
            end
        end
    end

    assign alloc_handle = HW'({ptr_reg[WIDX-1:0], free_idx}) + HW'(1);

    always_comb
    begin
        case (ctrl.uc.ptr_op)
            PTR_HOLD:   ptr_next = ptr_reg;
            PTR_ZERO:   ptr_next = '0;
            PTR_INC:    ptr_next = ptr_reg + PW'(1);
            PTR_INC_NT: ptr_next = ctrl.taken ? ptr_reg : ptr_reg + PW'(1);
            default:    ptr_next = ptr_reg;
        endcase
    end

    assign addr = (ctrl.uc.addr_sel == ADDR_HANDLE) ? hword : ptr_reg[WIDX-1:0];

    always_comb
    begin
        case (ctrl.uc.wsel)
            WSEL_ZERO:  wdata = '0;
            WSEL_SET:   wdata = rdata_reg | (rdata_reg + WORD_W'(1));
            WSEL_CLEAR: wdata = rdata_reg & ~(WORD_W'(1) << hbit);
            default:    wdata = rdata_reg;
        endcase
    end

    assign emit = ctrl.taken && (ctrl.uc.out != OUT_NONE);

    always_comb
    begin
        case (ctrl.uc.out)
            OUT_ALLOC:
            begin
                result_next.result_handle = alloc_handle[HANDLE_W-1:0];
                result_next.status        = ST_OK;
            end
            OUT_FREE:
            begin
                result_next.result_handle = handle_reg;
                result_next.status        = ST_OK;
            end
            OUT_FULL:
            begin
                result_next.result_handle = '0;
                result_next.status        = ST_FULL;
            end
            OUT_RANGE:
            begin
                result_next.result_handle = '0;
                result_next.status        = ST_RANGE;
            end
            default:
            begin
                result_next = result_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.uc.mem_wr)
        begin
            bitmap_mem[addr] <= wdata;
        end
        if (ctrl.uc.mem_rd)
        begin
            rdata_reg <= bitmap_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.uc.load_cmd && start)
        begin
            handle_reg <= cmd.slot_handle;
        end
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            done_reg <= emit;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- test/bitmap_slot_allocator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap first-fit slot allocator.
module bitmap_slot_allocator_tb;

    import bsa_pkg::*;

    localparam int unsigned SLOTS = DEF_MAX_WORDS * WORD_W;
    // Drain well past the longest scan at the end.
    localparam int DRAIN_CYCLES = 2 * DEF_MAX_WORDS + 40;

    // Mirror of the allocator: its own bitmap and search width, and the
    // result words the block still owes, oldest first.
    class slot_ledger;
        logic [WORD_W-1:0] used_bits [DEF_MAX_WORDS];
        logic [WIU_W-1:0]  words_searched;
        result_word_t      owed_results [$];
        int failures;
        int n_claimed;
        int n_full;
        int n_freed;
        int n_range;

        function new();
            foreach (used_bits[i])
                used_bits[i] = '0;
            words_searched = WIU_RESET;
            failures  = 0;
            n_claimed = 0;
            n_full    = 0;
            n_freed   = 0;
            n_range   = 0;
        endfunction

        function void set_words(logic [WIU_W-1:0] v);
            words_searched = v;
        endfunction

        // Predict the result word of an accepted command and apply it to the bitmap.
        function void take_cmd(cmd_word_t c);
            result_word_t r;
            int limit;
            int k;
            int b;
            int slot;
            bit hit;
            r.result_handle = '0;
            r.status        = ST_FULL;
            hit             = 1'b0;
            if (c.operation == OP_ALLOC)
            begin
                limit = (words_searched > DEF_MAX_WORDS) ? DEF_MAX_WORDS : words_searched;
                for (k = 0; k < limit && !hit; k++)
                    for (b = 0; b < WORD_W && !hit; b++)
                        if (!used_bits[k][b])
                        begin
                            hit             = 1'b1;
                            used_bits[k][b] = 1'b1;
                            r.result_handle = HANDLE_W'(k * WORD_W + b + 1);
                            r.status        = ST_OK;
                        end
                if (hit)
                    n_claimed++;
                else
                    n_full++;
            end
            else if (c.slot_handle == 0 || c.slot_handle > SLOTS)
            begin
                r.status = ST_RANGE;
                n_range++;
            end
            else
            begin
                slot = c.slot_handle - 1;
                used_bits[slot / WORD_W][slot % WORD_W] = 1'b0;
                r.result_handle = c.slot_handle;
                r.status        = ST_OK;
                n_freed++;
            end
            owed_results.push_back(r);
        endfunction

        // Compare one result word with the oldest owed one, field by field.
        function void match_result(result_word_t got);
            result_word_t want;
            if (owed_results.size() == 0)
            begin
                $display("%0t: result word with nothing owed: handle %0d status %0d",
                         $time, got.result_handle, got.status);
                failures++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (got.result_handle !== want.result_handle)
                begin
                    $display("%0t: result_handle mismatch: expected %0d, actual %0d",
                             $time, want.result_handle, got.result_handle);
                    failures++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, got.status);
                    failures++;
                end
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    cmd_word_t        cmd = '0;
    logic             done;
    result_word_t     result;
    logic             cfg_wr_en = 1'b0;
    logic [WIU_W-1:0] cfg_wr_data = '0;

    slot_ledger ledger;
    int words_sent = 0;
    int cfg_writes = 0;

    // Random phases: search width, command count, share of allocates (percent).
    // Small widths run the bitmap full; the saturating width scans all words.
    int phase_words [9] = '{1, 2, 127, 3, 64, 0, 10, 64, 33};
    int phase_items [9] = '{60, 100, 150, 80, 400, 20, 120, 350, 120};
    int phase_alloc [9] = '{85, 75, 70, 65, 80, 50, 55, 70, 60};

    bitmap_slot_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Capture every result word on its single done cycle; it cannot be held.
    always @(posedge clk)
    begin
        if (rst_n && done)
            ledger.match_result(result);
    end

    // Idle gap after a command word: mostly none or short, a few long, and
    // a stretch with no gaps at all every so often.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (words_sent % 160 < 40)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Handle to free: mostly inside the searched span where slots are in use,
    // then anywhere in the store, then zero, above the store, or any 12 bits.
    function automatic logic [HANDLE_W-1:0] pick_handle(int words);
        int span;
        int r;
        span = (words == 0) ? 1 : ((words > DEF_MAX_WORDS) ? DEF_MAX_WORDS : words);
        span = span * WORD_W;
        r = $urandom_range(0, 99);
        if (r < 55)
            return HANDLE_W'($urandom_range(1, span));
        if (r < 75)
            return HANDLE_W'($urandom_range(1, SLOTS));
        if (r < 80)
            return '0;
        if (r < 90)
            return HANDLE_W'($urandom_range(SLOTS + 1, (1 << HANDLE_W) - 1));
        return HANDLE_W'($urandom);
    endfunction

    // Present one command word, hold it until accepted, then idle at random.
    // Leave start high when no gap follows so the next word goes back to back.
    task automatic issue(input logic op, input logic [HANDLE_W-1:0] h);
        cmd_word_t c;
        int gap;
        c.operation   = op;
        c.slot_handle = h;
        gap = pick_gap();
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ledger.take_cmd(c);
        words_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start, wait until the block is idle with nothing owed, then write
    // the search width. Every command gives a result, so no extra pause.
    task automatic load_words(input logic [WIU_W-1:0] v);
        start <= 1'b0;
        while (ledger.owed_results.size() != 0 || busy)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ledger.set_words(v);
        cfg_writes++;
    endtask

    initial
    begin
        int p;
        int i;
        int n;
        int words;
        int pct;
        ledger = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: frees out of range at both ends and all ones, free of
        // free slots including the top handle, first-fit reuse of a hole.
        issue(OP_FREE, 12'd0);
        issue(OP_FREE, 12'd2049);
        issue(OP_FREE, 12'hFFF);
        issue(OP_FREE, 12'd2048);
        issue(OP_FREE, 12'd1);
        issue(OP_ALLOC, 12'hFFF);
        issue(OP_ALLOC, 12'h000);
        issue(OP_ALLOC, 12'h555);
        issue(OP_FREE, 12'd2);
        issue(OP_ALLOC, 12'hAAA);
        issue(OP_FREE, 12'hAAA);
        issue(OP_FREE, 12'h555);
        // Zero words searched: allocate always reports full.
        load_words(7'd0);
        issue(OP_ALLOC, 12'd0);
        issue(OP_FREE, 12'd3);
        issue(OP_ALLOC, 12'hFFF);
        load_words(7'd1);
        issue(OP_ALLOC, 12'd0);
        issue(OP_ALLOC, 12'd0);
        // Width above the store saturates to all words.
        load_words(7'd127);
        issue(OP_ALLOC, 12'd0);

        // Random phases; the bitmap carries over from one phase to the next.
        for (p = 0; p < 12; p++)
        begin
            if (p < 9)
            begin
                words = phase_words[p];
                n     = phase_items[p];
                pct   = phase_alloc[p];
            end
            else
            begin
                words = $urandom_range(0, (1 << WIU_W) - 1);
                n     = 50;
                pct   = $urandom_range(30, 90);
            end
            load_words(WIU_W'(words));
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 99) < pct)
                    issue(OP_ALLOC, HANDLE_W'($urandom));
                else
                    issue(OP_FREE, pick_handle(words));
            end
        end

        // Drain: wait for every owed word, then watch for strays.
        start <= 1'b0;
        while (ledger.owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("bsa_tb: %0d commands over %0d width settings", words_sent, cfg_writes);
        $display("bsa_tb: %0d claimed, %0d full, %0d freed, %0d out of range",
                 ledger.n_claimed, ledger.n_full, ledger.n_freed, ledger.n_range);
        if (ledger.failures == 0)
            $display("[bitmap_slot_allocator] OK");
        else
            $display("[bitmap_slot_allocator] ERROR");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #15_000_000;
        $display("[bitmap_slot_allocator] ERROR");
        $finish;
    end

endmodule
